// ----- hw/rtl/tpca_pkg.sv -----
// Shared types, constants and decode helpers for the touch packet calibration averager.
`timescale 1ns / 1ps

package tpca_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Bit positions and masks of the serial packet format.
  localparam int          SYNC_BIT     = 7;
  localparam int          PEN_DOWN_BIT = 6;
  localparam int          ORDER_BIT    = 4;
  localparam int          NEG_BIT      = 6;
  localparam logic [11:0] COORD_OFFSET = 12'd1024;

  // Field and accumulator widths.
  localparam int RX_W    = 8;
  localparam int COORD_W = 12;
  localparam int RAW_W   = 13;
  localparam int SUM_W   = 17;
  localparam int CNT_W   = 8;

  localparam logic [COORD_W-1:0] COORD_MAX = 12'd4094;

  // Default number of samples per calibration point.
  localparam int SAMPLE_TOTAL_DEF = 60;

  // Configuration port.
  localparam int         ADDR_W         = 3;
  localparam int         DATA_W         = 32;
  localparam logic [0:0] REG_CAL_ENABLE = 1'b0;

  typedef struct packed {
    logic            req_type;
    logic [RX_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               resp_valid;
    logic [RX_W-1:0]    resp_byte;
    logic               packet_complete;
    logic               avg_valid;
    logic [COORD_W-1:0] avg_x;
    logic [COORD_W-1:0] avg_y;
    logic               point_done;
    logic               pen_lifted;
  } result_t;

  // Decode one axis from its low and high bytes into 0..4126 (bit 7 of
  // the high byte is always clear inside a framed packet).
  function automatic logic [RAW_W-1:0] decode_axis(input logic [RX_W-1:0] lo,
                                                   input logic [RX_W-1:0] hi);
    logic        neg;
    logic [10:0] v;
    logic [11:0] base;
    neg  = hi[NEG_BIT];
    v    = 11'(lo[7:3]) + {1'b0, hi[5:0], 4'b0000};
    base = neg ? 12'(v) : 12'(v) + COORD_OFFSET;
    return {base, 1'b0};
  endfunction

endpackage

// ----- hw/rtl/touch_packet_calibration_averager_unit.sv -----
// Top level of the touch packet framer and calibration averager.
`timescale 1ns / 1ps

// Usage:
// Each request on the item channel (item_valid/item_ready, payload item) is
// either one serial byte from the touch controller or a start-point event.
// Every request yields exactly one result on the result channel
// (result_valid/result_ready, payload result): a response byte, a packet
// complete mark, the averaged point when it forms, and the point flags.
// The result is registered on the edge that accepts the request.
// Throughput is one request per cycle unless the receiver stalls, set by
// the single decode, accumulate and divide pass before the result register.
// The result register is reloaded whenever it is empty or being taken, so
// a stalled receiver holds item_ready low only while a result still waits.
// Reset (rst, synchronous) clears framing, sample count, sums, flags and
// cal_enable, and empties the result register. cal_enable is written through
// the APB-style port at byte address 0; pready is always high.
module touch_packet_calibration_averager_unit #(
  parameter int SAMPLE_TOTAL = tpca_pkg::SAMPLE_TOTAL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  tpca_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output tpca_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpca_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpca_pkg::DATA_W-1:0]  pwdata,
  output logic [tpca_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int SumW    = tpca_pkg::SUM_W;
  localparam int CntW    = tpca_pkg::CNT_W;
  localparam int HalfDiv = SAMPLE_TOTAL / 2;

  // Sample window bounds.
  localparam logic [CntW-1:0] TotalC = CntW'(SAMPLE_TOTAL);
  localparam logic [CntW-1:0] WinLoC = CntW'(SAMPLE_TOTAL / 4);
  localparam logic [CntW-1:0] WinHiC = CntW'(SAMPLE_TOTAL * 3 / 4);
  localparam logic [CntW-1:0] AvgAtC = CntW'(SAMPLE_TOTAL * 3 / 4 + 1);
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Division by HalfDiv as a multiply by a rounded-up reciprocal; exact for
  // every sum below 2**SumW.
  localparam int DivShift = SumW + $clog2(HalfDiv);
  localparam int RecipW   = SumW + 2;
  localparam int ProdW    = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << DivShift) + 64'(HalfDiv) - 64'd1) / 64'(HalfDiv));

  // State.
  logic                               cal_enable;
  logic [2:0]                         byte_position, byte_position_next;
  logic [tpca_pkg::RX_W-1:0]          pkt_byte [4];
  logic [tpca_pkg::RX_W-1:0]          pkt_wdata;
  logic [1:0]                         pkt_waddr;
  logic                               pkt_we;
  logic [CntW-1:0]                    sample_count, sample_count_next;
  logic [SumW-1:0]                    sum_x, sum_x_next;
  logic [SumW-1:0]                    sum_y, sum_y_next;
  logic                               done_flag, done_flag_next;
  logic                               pen_up_flag, pen_up_flag_next;
  tpca_pkg::result_t                  result_next;

  // Per-request datapath signals.
  logic                               accept;
  logic [2:0]                         pos;
  logic [tpca_pkg::RX_W-1:0]          rx;
  logic                               pen_down;
  logic                               swap_order;
  logic [tpca_pkg::RAW_W-1:0]         coord_x, coord_y;
  logic [SumW:0]                      add_x, add_y;
  logic [SumW-1:0]                    acc_x, acc_y;
  logic [ProdW-1:0]                   prod_x, prod_y;
  logic [SumW-1:0]                    quot_x, quot_y;
  logic [CntW-1:0]                    count_inc;
  logic                               in_window;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign pready     = 1'b1;

  // Configuration read-back.
  always_comb begin
    prdata = '0;
    if (paddr[tpca_pkg::ADDR_W-1:2] == tpca_pkg::REG_CAL_ENABLE) begin
      prdata = tpca_pkg::DATA_W'(cal_enable);
    end
  end

  // Axis decode of the packet being completed; the current byte is byte 4.
  assign rx         = item.rx_byte;
  assign pen_down   = pkt_byte[0][tpca_pkg::PEN_DOWN_BIT];
  assign swap_order = pkt_byte[0][tpca_pkg::ORDER_BIT];
  assign coord_x    = swap_order ? tpca_pkg::decode_axis(pkt_byte[1], pkt_byte[2])
                                 : tpca_pkg::decode_axis(pkt_byte[2], pkt_byte[1]);
  assign coord_y    = swap_order ? tpca_pkg::decode_axis(pkt_byte[3], rx)
                                 : tpca_pkg::decode_axis(rx, pkt_byte[3]);

  // Saturating accumulate inside the middle window, then the divide.
  assign in_window = (sample_count > WinLoC) && (sample_count <= WinHiC);
  assign add_x     = {1'b0, sum_x} + (SumW + 1)'(coord_x);
  assign add_y     = {1'b0, sum_y} + (SumW + 1)'(coord_y);
  assign acc_x     = !in_window ? sum_x : (add_x[SumW] ? {SumW{1'b1}} : add_x[SumW-1:0]);
  assign acc_y     = !in_window ? sum_y : (add_y[SumW] ? {SumW{1'b1}} : add_y[SumW-1:0]);
  assign prod_x    = ProdW'(acc_x) * ProdW'(Recip);
  assign prod_y    = ProdW'(acc_y) * ProdW'(Recip);
  assign quot_x    = SumW'(prod_x >> DivShift);
  assign quot_y    = SumW'(prod_y >> DivShift);
  assign count_inc = sample_count + CntW'(1);

  // Framing, sampling and result formation for one request.
  always_comb begin
    byte_position_next = byte_position;
    sample_count_next  = sample_count;
    sum_x_next         = sum_x;
    sum_y_next         = sum_y;
    done_flag_next     = done_flag;
    pen_up_flag_next   = pen_up_flag;
    pkt_we             = 1'b0;
    pkt_waddr          = 2'd0;
    pkt_wdata          = rx;
    result_next        = '0;
    pos                = (byte_position > 3'd4) ? 3'd0 : byte_position;

    if (accept) begin
      if (item.req_type == tpca_pkg::REQ_START) begin
        // Start of a new calibration point.
        sum_x_next       = '0;
        sum_y_next       = '0;
        done_flag_next   = 1'b0;
        pen_up_flag_next = 1'b0;
      end else if (pos == 3'd0) begin
        pkt_we = 1'b1;
        if (rx[tpca_pkg::SYNC_BIT]) begin
          byte_position_next = 3'd1;
        end else begin
          byte_position_next = 3'd0;
          if (rx != '0) begin
            result_next.resp_valid = 1'b1;
            result_next.resp_byte  = rx;
          end
        end
      end else if (rx[tpca_pkg::SYNC_BIT]) begin
        // A sync byte mid-packet restarts the frame.
        pkt_we             = 1'b1;
        byte_position_next = 3'd1;
      end else if (pos < 3'd4) begin
        pkt_we             = 1'b1;
        pkt_waddr          = pos[1:0];
        byte_position_next = pos + 3'd1;
      end else begin
        result_next.packet_complete = 1'b1;
        byte_position_next          = 3'd0;
        if (cal_enable) begin
          if (pen_down && sample_count <= TotalC) begin
            sample_count_next = count_inc;
            if (count_inc == AvgAtC) begin
              sum_x_next            = quot_x;
              sum_y_next            = quot_y;
              result_next.avg_valid = 1'b1;
              result_next.avg_x     = (quot_x > SumW'(tpca_pkg::COORD_MAX))
                                      ? tpca_pkg::COORD_MAX : quot_x[tpca_pkg::COORD_W-1:0];
              result_next.avg_y     = (quot_y > SumW'(tpca_pkg::COORD_MAX))
                                      ? tpca_pkg::COORD_MAX : quot_y[tpca_pkg::COORD_W-1:0];
            end else begin
              sum_x_next = acc_x;
              sum_y_next = acc_y;
            end
          end else if (!pen_down && sample_count < TotalC) begin
            // Pen lifted before the point was finished.
            sample_count_next = '0;
            sum_x_next        = '0;
            sum_y_next        = '0;
          end else if (sample_count > TotalC) begin
            done_flag_next = 1'b1;
            if (!pen_down) begin
              sample_count_next = '0;
              pen_up_flag_next  = 1'b1;
            end else if (sample_count != CntMax) begin
              sample_count_next = count_inc;
            end
          end
        end
      end
    end

    result_next.point_done = done_flag_next;
    result_next.pen_lifted = pen_up_flag_next;
  end

  // Control state, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_enable    <= 1'b0;
      byte_position <= '0;
      sample_count  <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      done_flag     <= 1'b0;
      pen_up_flag   <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (psel && penable && pwrite &&
          paddr[tpca_pkg::ADDR_W-1:2] == tpca_pkg::REG_CAL_ENABLE) begin
        cal_enable <= pwdata[0];
      end
      byte_position <= byte_position_next;
      sample_count  <= sample_count_next;
      sum_x         <= sum_x_next;
      sum_y         <= sum_y_next;
      done_flag     <= done_flag_next;
      pen_up_flag   <= pen_up_flag_next;
      if (item_ready) begin
        result_valid <= accept;
      end
    end
  end

  // Packet byte store and result payload need no reset.
  always_ff @(posedge clk) begin
    if (pkt_we) begin
      pkt_byte[pkt_waddr] <= pkt_wdata;
    end
    if (accept) begin
      result <= result_next;
    end
  end

  // The pen-up flag is only ever set together with the done flag.
  assert property (@(posedge clk) disable iff (rst) pen_up_flag |-> done_flag)
    else $error("pen_up_flag set without done_flag");

  // A start-point request clears both point flags.
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.req_type == tpca_pkg::REQ_START) |=> (!done_flag && !pen_up_flag))
    else $error("start-point request did not clear the flags");

  // An average only forms on the byte that completes a packet.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.avg_valid) |-> result.packet_complete)
    else $error("average formed outside a packet completion");

  // A response byte never coincides with a completed packet.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.resp_valid && result.packet_complete))
    else $error("response byte and packet completion on the same result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the touch packet framer and calibration averager: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLES    = tpca_pkg::SAMPLE_TOTAL_DEF;
  localparam int WIN_LO     = SAMPLES / 4;
  localparam int WIN_HI     = SAMPLES * 3 / 4;
  localparam int AVG_DIV    = (SAMPLES / 2) > 0 ? SAMPLES / 2 : 1;
  localparam int SUM_LIMIT  = (1 << tpca_pkg::SUM_W) - 1;
  localparam int CNT_LIMIT  = (1 << tpca_pkg::CNT_W) - 1;
  localparam int RANDOM_CAL = 360;
  localparam int RANDOM_RAW = 60;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_ready;
  tpca_pkg::item_t               item = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  tpca_pkg::result_t             result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [tpca_pkg::ADDR_W-1:0]   paddr = '0;
  logic [tpca_pkg::DATA_W-1:0]   pwdata = '0;
  logic [tpca_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // Requests waiting to be offered, and reports still owed by the block.
  tpca_pkg::item_t   pending_requests[$];
  tpca_pkg::result_t expected_reports[$];
  int      queued_count = 0;
  int      fail_count = 0;
  int      reports_seen = 0;

  // Shadow of the block's framing, sampling and configuration state.
  logic [2:0]  frame_pos = '0;
  logic [7:0]  pkt [0:4] = '{default: '0};
  int unsigned sample_cnt = 0;
  int unsigned acc_x = 0;
  int unsigned acc_y = 0;
  bit          done_r = 1'b0;
  bit          pen_up_r = 1'b0;
  bit          cal_on = 1'b0;

  // Sender and receiver pacing.
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int ready_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  touch_packet_calibration_averager_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One axis of a position packet, scaled to the calibrated range.
  function automatic int unsigned axis_coord(logic [7:0] lo, logic [7:0] hi);
    logic [7:0]  hi_cut;
    int unsigned v;
    hi_cut = hi[tpca_pkg::NEG_BIT] ? {2'b00, hi[5:0]} : hi;
    v = int'(lo[7:3]) + (int'(hi_cut) << 4);
    return hi[tpca_pkg::NEG_BIT] ? 2 * v : 2 * (int'(tpca_pkg::COORD_OFFSET) + v);
  endfunction

  // Work out the report for one request and advance the shadow state.
  function automatic tpca_pkg::result_t predict_report(tpca_pkg::item_t req);
    tpca_pkg::result_t r;
    logic [2:0]  p;
    bit          down;
    bit          swap;
    int unsigned s;
    int unsigned cx;
    int unsigned cy;
    r = '0;
    if (req.req_type == tpca_pkg::REQ_START) begin
      acc_x = 0;
      acc_y = 0;
      done_r = 1'b0;
      pen_up_r = 1'b0;
    end else begin
      p = (frame_pos > 3'd4) ? 3'd0 : frame_pos;
      pkt[p] = req.rx_byte;
      if (p == 3'd0) begin
        if (req.rx_byte[tpca_pkg::SYNC_BIT]) begin
          frame_pos = 3'd1;
        end else begin
          frame_pos = 3'd0;
          if (req.rx_byte != 8'd0) begin
            r.resp_valid = 1'b1;
            r.resp_byte  = req.rx_byte;
          end
        end
      end else if (req.rx_byte[tpca_pkg::SYNC_BIT]) begin
        pkt[0] = req.rx_byte;
        frame_pos = 3'd1;
      end else if (p < 3'd4) begin
        frame_pos = p + 3'd1;
      end else begin
        r.packet_complete = 1'b1;
        frame_pos = 3'd0;
        if (cal_on) begin
          down = pkt[0][tpca_pkg::PEN_DOWN_BIT];
          swap = pkt[0][tpca_pkg::ORDER_BIT];
          s = sample_cnt;
          if (down && s <= SAMPLES) begin
            // Only the middle window of the stroke is accumulated.
            if (s > WIN_LO && s <= WIN_HI) begin
              if (swap) begin
                cx = axis_coord(pkt[1], pkt[2]);
                cy = axis_coord(pkt[3], pkt[4]);
              end else begin
                cx = axis_coord(pkt[2], pkt[1]);
                cy = axis_coord(pkt[4], pkt[3]);
              end
              acc_x = (acc_x + cx > SUM_LIMIT) ? SUM_LIMIT : acc_x + cx;
              acc_y = (acc_y + cy > SUM_LIMIT) ? SUM_LIMIT : acc_y + cy;
            end
            s = (s + 1 > CNT_LIMIT) ? CNT_LIMIT : s + 1;
            sample_cnt = s;
            if (s == WIN_HI + 1) begin
              acc_x = acc_x / AVG_DIV;
              acc_y = acc_y / AVG_DIV;
              r.avg_valid = 1'b1;
              r.avg_x = (acc_x > tpca_pkg::COORD_MAX) ? tpca_pkg::COORD_MAX
                                                      : tpca_pkg::COORD_W'(acc_x);
              r.avg_y = (acc_y > tpca_pkg::COORD_MAX) ? tpca_pkg::COORD_MAX
                                                      : tpca_pkg::COORD_W'(acc_y);
            end
          end else if (!down && s < SAMPLES) begin
            // Pen lifted before the point was finished.
            sample_cnt = 0;
            acc_x = 0;
            acc_y = 0;
          end else if (s > SAMPLES) begin
            done_r = 1'b1;
            if (sample_cnt < CNT_LIMIT) sample_cnt = sample_cnt + 1;
            if (!down) begin
              sample_cnt = 0;
              pen_up_r = 1'b1;
            end
          end
        end
      end
    end
    r.point_done = done_r;
    r.pen_lifted = pen_up_r;
    return r;
  endfunction

  task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch on %s at report %0d: expected %0h, got %0h",
                 label, reports_seen, want, got);
      end
    end
  endtask

  // Driver: offers queued requests in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_reports.push_back(predict_report(item));
      end
      if (item_valid && !item_ready) begin
        // The offered request stays put until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        item <= pending_requests.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each report and paces result_ready.
  always @(posedge clk) begin
    bit ready_next;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("report %0d arrived with none expected: %p", reports_seen, result);
          end
        end else begin
          tpca_pkg::result_t want;
          want = expected_reports.pop_front();
          check_field("resp_valid", 16'(want.resp_valid), 16'(result.resp_valid));
          check_field("resp_byte", 16'(want.resp_byte), 16'(result.resp_byte));
          check_field("packet_complete", 16'(want.packet_complete),
                      16'(result.packet_complete));
          check_field("avg_valid", 16'(want.avg_valid), 16'(result.avg_valid));
          check_field("avg_x", 16'(want.avg_x), 16'(result.avg_x));
          check_field("avg_y", 16'(want.avg_y), 16'(result.avg_y));
          check_field("point_done", 16'(want.point_done), 16'(result.point_done));
          check_field("pen_lifted", 16'(want.pen_lifted), 16'(result.pen_lifted));
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (ready_mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 1) == 1);
        2: ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = (stall_phase % 3 != 0);
      endcase
      // One long hold-off so the block fills and backs up its input.
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!long_hold_done && reports_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left = 250;
        ready_next = 1'b0;
      end
      result_ready <= ready_next;
    end
  end

  task automatic push_byte(logic [7:0] b);
    pending_requests.push_back('{req_type: tpca_pkg::REQ_BYTE, rx_byte: b});
    queued_count++;
  endtask

  task automatic push_start();
    pending_requests.push_back('{req_type: tpca_pkg::REQ_START, rx_byte: 8'($urandom)});
    queued_count++;
  endtask

  // A full position packet with random order bit and coordinates.
  task automatic push_packet(bit pen_down);
    push_byte({1'b1, pen_down, 6'($urandom)});
    repeat (4) push_byte({1'b0, 7'($urandom)});
  endtask

  // Traffic that is not a clean packet: responses, zeros, cut packets, starts.
  task automatic push_noise();
    case ($urandom_range(0, 4))
      0: push_byte({1'b0, 7'($urandom_range(1, 127))});
      1: push_byte(8'h00);
      2: begin
        push_byte({1'b1, 7'($urandom)});
        repeat ($urandom_range(0, 3)) push_byte({1'b0, 7'($urandom)});
      end
      3: push_start();
      default: push_byte(8'($urandom));
    endcase
  endtask

  // One pen stroke: pen-down packets of a chosen length, then a lift.
  task automatic push_stroke();
    int n;
    case ($urandom_range(0, 5))
      0: n = $urandom_range(1, WIN_LO);
      1: n = $urandom_range(WIN_LO + 1, WIN_HI);
      2: n = WIN_HI + 1;
      3: n = SAMPLES;
      4: n = $urandom_range(SAMPLES + 1, SAMPLES + 15);
      default: n = $urandom_range(WIN_HI + 1, SAMPLES - 1);
    endcase
    if ($urandom_range(0, 1)) push_start();
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) push_noise();
      push_packet(1'b1);
    end
    repeat ($urandom_range(1, 2)) push_packet(1'b0);
  endtask

  // Wait until every request is taken and every report checked.
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || item_valid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cal_enable(logic value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {tpca_pkg::REG_CAL_ENABLE, 2'b00};
    pwdata  <= tpca_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cal_on = value;
  endtask

  initial begin
    int mark;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Framing only, with calibration off as after reset.
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(8'h00);
    push_byte(8'h55);
    push_byte(8'h2A);
    push_byte(8'h80);
    push_byte(8'h10);
    push_byte(8'hC0);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h43);
    push_byte(8'h04);
    push_start();
    drain();

    // Calibration on: random strokes with noise mixed in.
    write_cal_enable(1'b1);
    mark = queued_count;
    while (queued_count - mark < RANDOM_CAL) push_stroke();
    drain();

    // Calibration off: packets are framed but only start requests change sampling state.
    write_cal_enable(1'b0);
    mark = queued_count;
    while (queued_count - mark < RANDOM_RAW) begin
      if ($urandom_range(0, 3) == 0) push_noise();
      else push_packet($urandom_range(0, 1));
    end
    drain();

    // Calibration on again: a fresh point with a short press and a lift.
    write_cal_enable(1'b1);
    push_start();
    repeat (2) push_packet(1'b1);
    push_packet(1'b0);
    drain();

    if (fail_count == 0) begin
      $display("touch_packet_calibration_averager_unit test passed");
    end else begin
      $display("touch_packet_calibration_averager_unit test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("touch_packet_calibration_averager_unit test failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tpca_pkg.sv
hw/rtl/touch_packet_calibration_averager_unit.sv
tb/sv/tb_top.sv
